// ===== sv/hbd_pkg.sv =====
// Constants and register indexes shared by the HRPT bit deframer.
package hbd_pkg;

  localparam int unsigned WordBits      = 10;
  localparam int unsigned SyncWordCount = 6;
  localparam int unsigned SyncBits      = WordBits * SyncWordCount;
  localparam int unsigned FrameBits     = 14;
  localparam int unsigned BitCntBits    = 4;
  localparam int unsigned BurstCntBits  = 3;
  localparam int unsigned CfgIdxBits    = 8;
  localparam int unsigned CfgDataBits   = 64;
  localparam int unsigned InDataBits    = 8;
  localparam int unsigned OutDataBits   = 16;

  localparam logic [FrameBits-1:0]    FrameWordsRst = FrameBits'(11090);
  localparam logic [FrameBits-1:0]    SyncWordsFw   = FrameBits'(SyncWordCount);
  localparam logic [BitCntBits-1:0]   WordBitsCnt   = BitCntBits'(WordBits);
  localparam logic [BurstCntBits-1:0] SyncBurstCnt  = BurstCntBits'(SyncWordCount);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SYNC_PATTERN = 8'd0,
    CFG_FRAME_WORDS  = 8'd1
  } cfg_idx_e;

endpackage

// ===== sv/hrpt_bit_deframer_core.sv =====
// HRPT minor frame bit deframer: sync hunt, word packing and output burst stage.
//
// The core takes one bit sample per clock cycle at two samples per symbol and
// keeps every other sample; while hunting only samples that differ from their
// predecessor are taken. The whole decision for a sample is made in the cycle
// it is accepted. A sync match yields a burst of six 10-bit words, which the
// output stage sends one per cycle while m_axis_tready_i is high; in synced
// mode a data word follows every ten taken bits. One further burst or word
// can wait in a holding register behind the output stage, so s_axis_tready_o
// drops only while that holding register is full: when the output side stalls,
// or when a new sync burst arrives while the last one is still being sent,
// which a constant sync pattern allows every second sample. Configuration
// should be written while the core is idle; cfg_ready_o is always high.
module hrpt_bit_deframer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hbd_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [hbd_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [hbd_pkg::InDataBits-1:0]     s_axis_tdata_i,  // [0] in_bit
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [hbd_pkg::OutDataBits-1:0]    m_axis_tdata_o,  // [9:0] frame_word
  output logic                               m_axis_tlast_o   // last_of_run
);
  import hbd_pkg::*;

  // Configuration registers.
  logic [SyncBits-1:0]  sync_pattern_q;
  logic [FrameBits-1:0] frame_words_q;

  // Deframer state.
  logic                  synced_q, synced_d;
  logic                  half_phase_q, half_phase_d;
  logic                  prev_bit_q;
  logic [SyncBits-1:0]   sync_shift_q, sync_shift_d;
  logic [WordBits-1:0]   word_shift_q, word_shift_d;
  logic [BitCntBits-1:0] bits_left_q, bits_left_d;
  logic [FrameBits-1:0]  words_left_q, words_left_d;

  // Output burst stage and holding register.
  logic [SyncBits-1:0]     burst_q, burst_d;
  logic [BurstCntBits-1:0] burst_cnt_q, burst_cnt_d;
  logic [SyncBits-1:0]     pend_q, pend_d;
  logic [BurstCntBits-1:0] pend_cnt_q, pend_cnt_d;
  logic                    pend_valid_q, pend_valid_d;

  logic                    in_accept;
  logic                    in_bit;
  logic                    take;
  logic [SyncBits-1:0]     sync_next;
  logic [WordBits-1:0]     word_next;
  logic [BitCntBits-1:0]   bits_dec;
  logic [FrameBits-1:0]    words_dec;
  logic                    res_valid;
  logic [SyncBits-1:0]     res_words;
  logic [BurstCntBits-1:0] res_cnt;
  logic                    out_take;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = ~pend_valid_q;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign in_bit          = s_axis_tdata_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pattern_q <= '0;
      frame_words_q  <= FrameWordsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_PATTERN: sync_pattern_q <= cfg_data_i[SyncBits-1:0];
        CFG_FRAME_WORDS:  frame_words_q  <= cfg_data_i[FrameBits-1:0];
        default: ;
      endcase
    end
  end

  // A sample is taken on the active phase, and while hunting only on a transition.
  assign take      = half_phase_q & ((in_bit ^ prev_bit_q) | synced_q);
  assign sync_next = {sync_shift_q[SyncBits-2:0], in_bit};
  assign word_next = {word_shift_q[WordBits-2:0], in_bit};
  assign bits_dec  = bits_left_q - BitCntBits'(1);
  assign words_dec = words_left_q - FrameBits'(1);

  always_comb begin
    synced_d     = synced_q;
    // A sample that is not taken leaves the core ready to take the next one.
    half_phase_d = 1'b1;
    sync_shift_d = sync_shift_q;
    word_shift_d = word_shift_q;
    bits_left_d  = bits_left_q;
    words_left_d = words_left_q;
    res_valid    = 1'b0;
    res_words    = sync_pattern_q;
    res_cnt      = SyncBurstCnt;
    if (take) begin
      half_phase_d = 1'b0;
      if (!synced_q) begin
        sync_shift_d = sync_next;
        if (sync_next == sync_pattern_q) begin
          res_valid    = 1'b1;
          bits_left_d  = WordBitsCnt;
          word_shift_d = '0;
          if (frame_words_q > SyncWordsFw) begin
            words_left_d = frame_words_q - SyncWordsFw;
            synced_d     = 1'b1;
          end else begin
            words_left_d = '0;
          end
        end
      end else begin
        word_shift_d = word_next;
        bits_left_d  = bits_dec;
        if (bits_dec == '0) begin
          res_valid    = 1'b1;
          res_words    = {word_next, {(SyncBits-WordBits){1'b0}}};
          res_cnt      = BurstCntBits'(1);
          word_shift_d = '0;
          bits_left_d  = WordBitsCnt;
          words_left_d = words_dec;
          if (words_dec == '0) begin
            synced_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q     <= 1'b0;
      half_phase_q <= 1'b1;
      prev_bit_q   <= 1'b0;
      sync_shift_q <= '0;
      word_shift_q <= '0;
      bits_left_q  <= WordBitsCnt;
      words_left_q <= '0;
    end else if (in_accept) begin
      synced_q     <= synced_d;
      half_phase_q <= half_phase_d;
      prev_bit_q   <= in_bit;
      sync_shift_q <= sync_shift_d;
      word_shift_q <= word_shift_d;
      bits_left_q  <= bits_left_d;
      words_left_q <= words_left_d;
    end
  end

  // The burst register shifts its top word out; a new result goes behind it
  // into the holding register if the burst is still busy.
  assign out_take = (burst_cnt_q != '0) & m_axis_tready_i;

  always_comb begin
    burst_d      = burst_q;
    burst_cnt_d  = burst_cnt_q;
    pend_d       = pend_q;
    pend_cnt_d   = pend_cnt_q;
    pend_valid_d = pend_valid_q;
    if (out_take) begin
      burst_d     = {burst_q[SyncBits-WordBits-1:0], {WordBits{1'b0}}};
      burst_cnt_d = burst_cnt_q - BurstCntBits'(1);
    end
    if ((burst_cnt_d == '0) && pend_valid_q) begin
      burst_d      = pend_q;
      burst_cnt_d  = pend_cnt_q;
      pend_valid_d = 1'b0;
    end
    if (in_accept && res_valid) begin
      if (burst_cnt_d == '0) begin
        burst_d     = res_words;
        burst_cnt_d = res_cnt;
      end else begin
        pend_d       = res_words;
        pend_cnt_d   = res_cnt;
        pend_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_cnt_q  <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      burst_cnt_q  <= burst_cnt_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q    <= burst_d;
    pend_q     <= pend_d;
    pend_cnt_q <= pend_cnt_d;
  end

  assign m_axis_tvalid_o = burst_cnt_q != '0;
  assign m_axis_tdata_o  = {{(OutDataBits-WordBits){1'b0}}, burst_q[SyncBits-1 -: WordBits]};
  assign m_axis_tlast_o  = burst_cnt_q == BurstCntBits'(1);

  a_pend_behind_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (burst_cnt_q != '0))
    else $error("holding register full while burst stage empty");

  a_burst_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_cnt_q <= SyncBurstCnt)
    else $error("burst count beyond six words");

  a_synced_words_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    synced_q |-> (words_left_q != '0))
    else $error("synced with no frame words left");

  a_bits_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bits_left_q != '0) && (bits_left_q <= WordBitsCnt))
    else $error("bit counter out of range");

  a_stall_holds_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output word changed");

endmodule
